[rtl/core/closest_ray_segment_hit_assert.svh]
// assertion macros for the ray caster core
`ifndef CLOSEST_RAY_SEGMENT_HIT_ASSERT_SVH
`define CLOSEST_RAY_SEGMENT_HIT_ASSERT_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define CRSH_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define CRSH_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define CRSH_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define CRSH_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

[rtl/core/crsh_pkg.sv]
`default_nettype none
package crsh_pkg;

	// request function codes
	localparam logic [1:0] FN_BEGIN   = 2'd0;
	localparam logic [1:0] FN_SEGMENT = 2'd1;
	localparam logic [1:0] FN_FINISH  = 2'd2;

	// configuration register indexes
	localparam int          IDX_BITS  = 1;
	localparam logic [0:0]  REG_DIR_X = 1'd0;
	localparam logic [0:0]  REG_DIR_Y = 1'd1;

	// reset direction: 100.0 in Q7.8
	localparam int DIR_X_RESET = 25600;

	// sequencer states
	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_MUL   = 7'b0000010,
		ST_CHECK = 7'b0000100,
		ST_CX    = 7'b0001000,
		ST_CY    = 7'b0010000,
		ST_DIST  = 7'b0100000,
		ST_UPD   = 7'b1000000
	} crsh_state_t;

	// hit coordinate unit phases
	typedef enum logic [3:0] {
		PH_IDLE = 4'b0001,
		PH_MUL  = 4'b0010,
		PH_DIV  = 4'b0100,
		PH_FIN  = 4'b1000
	} crsh_phase_t;

endpackage
`default_nettype wire

[rtl/core/crsh_in_if.sv]
`default_nettype none
interface crsh_in_if #(parameter int CW = 24);
	logic                 valid;
	logic                 ready;
	logic [1:0]           func;
	logic signed [CW-1:0] origin_x;
	logic signed [CW-1:0] origin_y;
	logic signed [CW-1:0] seg_start_x;
	logic signed [CW-1:0] seg_start_y;
	logic signed [CW-1:0] seg_end_x;
	logic signed [CW-1:0] seg_end_y;

	modport source (output valid, func, origin_x, origin_y, seg_start_x, seg_start_y,
		seg_end_x, seg_end_y, input ready);
	modport sink (input valid, func, origin_x, origin_y, seg_start_x, seg_start_y,
		seg_end_x, seg_end_y, output ready);
endinterface
`default_nettype wire

[rtl/core/crsh_out_if.sv]
`default_nettype none
interface crsh_out_if #(parameter int CW = 24);
	logic                 valid;
	logic                 ready;
	logic                 hit_found;
	logic signed [CW-1:0] hit_x;
	logic signed [CW-1:0] hit_y;

	modport source (output valid, hit_found, hit_x, hit_y, input ready);
	modport sink (input valid, hit_found, hit_x, hit_y, output ready);
endinterface
`default_nettype wire

[rtl/core/crsh_mul.sv]
`default_nettype none
module crsh_mul #(
	parameter int M = 26
) (
	input  wire logic                  clk,
	input  wire logic signed [M-1:0]   a,
	input  wire logic signed [M-1:0]   b,
	output logic signed [2*M-1:0]      prod
);
	// shared signed multiplier, registered product
	logic signed [2*M-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

	assign prod = prod_q;
endmodule
`default_nettype wire

[rtl/core/crsh_coord.sv]
`default_nettype none
module crsh_coord import crsh_pkg::*; #(
	parameter int C = 24,
	parameter int D = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [2*C+2:0]        tn,
	input  wire logic [C+D+1:0]        den,
	input  wire logic signed [D-1:0]   dir,
	input  wire logic signed [C-1:0]   org,
	output logic                       done,
	output logic signed [C-1:0]        h
);
	localparam int TNW  = 2*C + 3;
	localparam int DENW = C + D + 2;
	localparam int PW   = TNW + D;
	localparam int CNTW = $clog2(PW + 1);

	crsh_phase_t          ph_q;
	logic [CNTW-1:0]      cnt_q;
	logic [D-1:0]         m_q;
	logic                 neg_q;
	logic signed [C-1:0]  org_q;
	logic [PW-1:0]        p_q;
	logic [DENW-1:0]      r_q;
	logic [C:0]           q_q;
	logic                 ovf_q;
	logic                 done_q;
	logic signed [C-1:0]  h_q;

	logic [PW-1:0]        addend;
	logic [DENW:0]        r2;
	logic [DENW:0]        rsub;
	logic                 ge;
	logic [D-1:0]         dir_mag;
	logic                 sat;
	logic signed [C+1:0]  qs;
	logic signed [C+1:0]  sum;
	logic signed [C+1:0]  hmax;
	logic signed [C+1:0]  hmin;
	logic signed [C-1:0]  res;

	// shift-add multiply step and restoring divide step
	always_comb begin
		dir_mag = dir[D-1] ? D'(-dir) : D'(dir);
		addend  = m_q[D-1] ? PW'(tn) : '0;
		r2      = {r_q, p_q[PW-1]};
		ge      = r2 >= {1'b0, den};
		rsub    = r2 - {1'b0, den};
	end

	// offset apply and saturation
	always_comb begin
		sat  = ovf_q | q_q[C];
		qs   = $signed({2'b00, q_q[C-1:0]});
		sum  = (C+2)'(org_q) + (neg_q ? -qs : qs);
		hmax = (C+2)'($signed({1'b0, {(C-1){1'b1}}}));
		hmin = -hmax - (C+2)'(1);
		if (sat)
			res = neg_q ? C'(hmin) : C'(hmax);
		else if (sum > hmax)
			res = C'(hmax);
		else if (sum < hmin)
			res = C'(hmin);
		else
			res = sum[C-1:0];
	end

	// phase sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= PH_IDLE;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (ph_q == PH_FIN);
			case (ph_q)
				PH_IDLE: begin
					if (start) begin
						ph_q  <= PH_MUL;
						cnt_q <= CNTW'(D);
					end
				end
				PH_MUL: begin
					cnt_q <= cnt_q - CNTW'(1);
					if (cnt_q == CNTW'(1)) begin
						ph_q  <= PH_DIV;
						cnt_q <= CNTW'(PW);
					end
				end
				PH_DIV: begin
					cnt_q <= cnt_q - CNTW'(1);
					if (cnt_q == CNTW'(1))
						ph_q <= PH_FIN;
				end
				PH_FIN: begin
					ph_q <= PH_IDLE;
				end
				default: ph_q <= PH_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (ph_q)
			PH_IDLE: begin
				if (start) begin
					p_q   <= '0;
					m_q   <= dir_mag;
					neg_q <= dir[D-1];
					org_q <= org;
				end
			end
			PH_MUL: begin
				p_q <= {p_q[PW-2:0], 1'b0} + addend;
				m_q <= {m_q[D-2:0], 1'b0};
				if (cnt_q == CNTW'(1)) begin
					r_q   <= '0;
					q_q   <= '0;
					ovf_q <= 1'b0;
				end
			end
			PH_DIV: begin
				p_q   <= {p_q[PW-2:0], 1'b0};
				r_q   <= ge ? rsub[DENW-1:0] : r2[DENW-1:0];
				q_q   <= {q_q[C-1:0], ge};
				ovf_q <= ovf_q | q_q[C];
			end
			PH_FIN: h_q <= res;
			default: ;
		endcase
	end

	assign done = done_q;
	assign h    = h_q;
endmodule
`default_nettype wire

[rtl/core/closest_ray_segment_hit.sv]
// Nearest-hit 2D ray caster. A begin request loads the ray origin and clears the
// nearest-hit record, a segment request tests one segment against the ray whose
// direction comes from the two direction registers (Q7.8, to be written by the
// user only while idle; the block does not enforce this), and a finish request
// returns the nearest hit or hit_found=0 with zero coordinates. Coordinates are
// signed Q15.8. A segment that misses ends at the hit check; for one that hits,
// the hit coordinate unit forms t*direction with a shift-add multiplier and then
// divides with a restoring divider, one bit per cycle, once for x and once for y.
// The products in front of it run through one shared multiplier, one per cycle.
`default_nettype none
`include "closest_ray_segment_hit_assert.svh"
module closest_ray_segment_hit import crsh_pkg::*; #(
	parameter int COORD_BITS = 24,
	parameter int DIR_BITS   = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	crsh_in_if.sink                   req,
	crsh_out_if.source                rsp,
	input  wire logic                 cfg_we,
	input  wire logic [IDX_BITS-1:0]  cfg_idx,
	input  wire logic [DIR_BITS-1:0]  cfg_data
);
	localparam int C    = COORD_BITS;
	localparam int D    = DIR_BITS;
	localparam int M    = ((C > D) ? C : D) + 2;
	localparam int DENW = C + D + 2;
	localparam int TNW  = 2*C + 3;
	localparam int DSW  = 2*C + 2;

	crsh_state_t           st_q;
	logic [2:0]            step_q;
	logic signed [D-1:0]   dir_x_q, dir_y_q;
	logic signed [C-1:0]   org_x_q, org_y_q;
	logic signed [C-1:0]   sx_q, sy_q, ex_q, ey_q;
	logic signed [C-1:0]   best_x_q, best_y_q;
	logic [DSW-1:0]        best_d_q;
	logic                  seen_q;
	logic signed [DENW-1:0] den_q, sn_q;
	logic signed [TNW-1:0] tn_q;
	logic [DENW-1:0]       dpos_q;
	logic [TNW-1:0]        tpos_q;
	logic signed [C-1:0]   hx_q, hy_q;
	logic [DSW-1:0]        sqx_q, dist_q;
	logic                  cstart_q;
	logic                  out_v_q, out_f_q;
	logic signed [C-1:0]   out_x_q, out_y_q;

	logic                  acc;
	logic signed [C:0]     da, db, oy_sy, sx_ox, sy_oy, ox_sx, ddx, ddy;
	logic signed [M-1:0]   mul_a, mul_b;
	logic signed [2*M-1:0] prod;
	logic                  den_pos;
	logic signed [DENW-1:0] dn, snn;
	logic signed [TNW-1:0] tnn;
	logic                  cdone;
	logic signed [C-1:0]   ch;

	assign req.ready = (st_q == ST_IDLE) && (!out_v_q || rsp.ready);
	assign acc       = req.valid && req.ready;

	// segment differences
	always_comb begin
		da    = (C+1)'(ex_q) - (C+1)'(sx_q);
		db    = (C+1)'(ey_q) - (C+1)'(sy_q);
		oy_sy = (C+1)'(org_y_q) - (C+1)'(sy_q);
		sx_ox = (C+1)'(sx_q) - (C+1)'(org_x_q);
		sy_oy = -oy_sy;
		ox_sx = -sx_ox;
		ddx   = (C+1)'(hx_q) - (C+1)'(org_x_q);
		ddy   = (C+1)'(hy_q) - (C+1)'(org_y_q);
	end

	// shared multiplier operand select
	always_comb begin
		mul_a = M'(ddy);
		mul_b = M'(ddy);
		if (st_q == ST_MUL) begin
			case (step_q)
				3'd0: begin mul_a = M'(da); mul_b = M'(dir_y_q); end
				3'd1: begin mul_a = M'(db); mul_b = M'(dir_x_q); end
				3'd2: begin mul_a = M'(dir_x_q); mul_b = M'(sy_oy); end
				3'd3: begin mul_a = M'(dir_y_q); mul_b = M'(ox_sx); end
				3'd4: begin mul_a = M'(da); mul_b = M'(oy_sy); end
				default: begin mul_a = M'(db); mul_b = M'(sx_ox); end
			endcase
		end else if (step_q == 3'd0) begin
			mul_a = M'(ddx);
			mul_b = M'(ddx);
		end
	end

	crsh_mul #(.M(M)) u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	// sign normalization of the hit test
	always_comb begin
		den_pos = den_q > 0;
		dn      = den_pos ? den_q : -den_q;
		snn     = den_pos ? sn_q : -sn_q;
		tnn     = den_pos ? -tn_q : tn_q;
	end

	crsh_coord #(.C(C), .D(D)) u_coord (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cstart_q),
		.tn     (tpos_q),
		.den    (dpos_q),
		.dir    ((st_q == ST_CY) ? dir_y_q : dir_x_q),
		.org    ((st_q == ST_CY) ? org_y_q : org_x_q),
		.done   (cdone),
		.h      (ch)
	);

	// sequencer and ray state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			step_q   <= '0;
			dir_x_q  <= D'(DIR_X_RESET);
			dir_y_q  <= '0;
			org_x_q  <= '0;
			org_y_q  <= '0;
			best_x_q <= '0;
			best_y_q <= '0;
			seen_q   <= 1'b0;
			cstart_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			// result valid: set by a finish request, cleared when taken
			if (acc && req.func == FN_FINISH)
				out_v_q <= 1'b1;
			else if (rsp.valid && rsp.ready)
				out_v_q <= 1'b0;
			// configuration writes
			if (cfg_we) begin
				case (cfg_idx)
					REG_DIR_X: dir_x_q <= cfg_data;
					REG_DIR_Y: dir_y_q <= cfg_data;
					default: ;
				endcase
			end
			case (st_q)
				ST_IDLE: begin
					if (acc) begin
						case (req.func)
							FN_BEGIN: begin
								org_x_q  <= req.origin_x;
								org_y_q  <= req.origin_y;
								best_x_q <= '0;
								best_y_q <= '0;
								seen_q   <= 1'b0;
							end
							FN_SEGMENT: begin
								st_q   <= ST_MUL;
								step_q <= '0;
							end
							default: ;
						endcase
					end
				end
				ST_MUL: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'd6)
						st_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (den_q == 0 || snn < 0 || snn > dn || tnn < 0) begin
						cstart_q <= 1'b0;
						st_q     <= ST_IDLE;
					end else begin
						cstart_q <= 1'b1;
						st_q     <= ST_CX;
					end
				end
				ST_CX: begin
					cstart_q <= cdone;
					if (cdone)
						st_q <= ST_CY;
				end
				ST_CY: begin
					cstart_q <= 1'b0;
					if (cdone) begin
						st_q   <= ST_DIST;
						step_q <= '0;
					end
				end
				ST_DIST: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'd2)
						st_q <= ST_UPD;
				end
				ST_UPD: begin
					if (!seen_q || dist_q < best_d_q) begin
						best_x_q <= hx_q;
						best_y_q <= hy_q;
						seen_q   <= 1'b1;
					end
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				if (acc && req.func == FN_SEGMENT) begin
					sx_q <= req.seg_start_x;
					sy_q <= req.seg_start_y;
					ex_q <= req.seg_end_x;
					ey_q <= req.seg_end_y;
				end
				if (acc && req.func == FN_FINISH) begin
					out_f_q <= seen_q;
					out_x_q <= seen_q ? best_x_q : '0;
					out_y_q <= seen_q ? best_y_q : '0;
				end
			end
			ST_MUL: begin
				case (step_q)
					3'd1: den_q <= DENW'(prod);
					3'd2: den_q <= den_q - DENW'(prod);
					3'd3: sn_q  <= DENW'(prod);
					3'd4: sn_q  <= sn_q + DENW'(prod);
					3'd5: tn_q  <= TNW'(prod);
					3'd6: tn_q  <= tn_q + TNW'(prod);
					default: ;
				endcase
			end
			ST_CHECK: begin
				dpos_q <= DENW'(dn);
				tpos_q <= TNW'(tnn);
			end
			ST_CX: if (cdone) hx_q <= ch;
			ST_CY: if (cdone) hy_q <= ch;
			ST_DIST: begin
				if (step_q == 3'd1)
					sqx_q <= DSW'(prod);
				if (step_q == 3'd2)
					dist_q <= sqx_q + DSW'(prod);
			end
			ST_UPD: begin
				if (!seen_q || dist_q < best_d_q)
					best_d_q <= dist_q;
			end
			default: ;
		endcase
	end

	assign rsp.valid     = out_v_q;
	assign rsp.hit_found = out_f_q;
	assign rsp.hit_x     = out_x_q;
	assign rsp.hit_y     = out_y_q;

	// checks
	`CRSH_ASSERT_IMP(a_done_in_coord, clk, arst_n, cdone, st_q == ST_CX || st_q == ST_CY, "coordinate done outside coordinate states")
	`CRSH_ASSERT_NXT(a_finish_result, clk, arst_n, acc && req.func == FN_FINISH, rsp.valid, "finish request gave no result")
	`CRSH_ASSERT_IMP(a_miss_zero, clk, arst_n, rsp.valid && !rsp.hit_found, rsp.hit_x == 0 && rsp.hit_y == 0, "miss result with nonzero coordinates")
endmodule
`default_nettype wire
